### sv/flight_phase_sequencer_defines.svh
// ----------------------------------------------------------------------------
// flight_phase_sequencer_defines.svh
// Assertion macros shared by the flight phase sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef FLIGHT_PHASE_SEQUENCER_DEFINES_SVH
`define FLIGHT_PHASE_SEQUENCER_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define FPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is asserted
`define FPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Widths, register codes, reset values and shared types of the flight phase
// sequencer.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int PRESSURE_W  = 17;
    localparam int ACCEL_W     = 19;
    localparam int TIME_W      = 32;
    localparam int RATIO_W     = 16;
    localparam int COUNT_W     = 7;
    localparam int PHASE_W     = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam int HISTORY_DEPTH_DEF = 8;

    // input transaction layout
    localparam int IN_TDATA_W      = 72;
    localparam int IN_TUSER_W      = 2;
    localparam int IN_PRESSURE_LSB = 0;
    localparam int IN_ACCEL_LSB    = IN_PRESSURE_LSB + PRESSURE_W;
    localparam int IN_TIME_LSB     = IN_ACCEL_LSB + ACCEL_W;
    localparam int IN_DROGUE_OK    = IN_TIME_LSB + TIME_W;
    localparam int IN_BARO_VALID   = 0;
    localparam int IN_IMU_VALID    = 1;

    // output transaction layout
    localparam int OUT_TDATA_W      = 40;
    localparam int OUT_PHASE_LSB    = 0;
    localparam int OUT_FIRE_DROGUE  = OUT_PHASE_LSB + PHASE_W;
    localparam int OUT_FIRE_MAIN    = OUT_FIRE_DROGUE + 1;
    localparam int OUT_PRESSURE_LSB = OUT_FIRE_MAIN + 1;
    localparam int OUT_ACCEL_LSB    = OUT_PRESSURE_LSB + PRESSURE_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LAUNCH_ACCEL = 3'd0,
        CFG_LAUNCH_RATIO = 3'd1,
        CFG_MAIN_RATIO   = 3'd2,
        CFG_CONFIRM      = 3'd3,
        CFG_ASCENT_TO    = 3'd4,
        CFG_DROGUE_TO    = 3'd5
    } t_cfg_index;

    localparam logic [ACCEL_W-1:0] RST_ACCEL_THR    = 19'd30000;
    localparam logic [RATIO_W-1:0] RST_LAUNCH_RATIO = 16'd64000;
    localparam logic [RATIO_W-1:0] RST_MAIN_RATIO   = 16'd63000;
    localparam logic [COUNT_W-1:0] RST_CONFIRM      = 7'd5;
    localparam logic [TIME_W-1:0]  RST_ASCENT_TO    = 32'd30000;
    localparam logic [TIME_W-1:0]  RST_DROGUE_TO    = 32'd120000;

    typedef struct packed {
        logic [ACCEL_W-1:0] accel_thr;     // two's complement
        logic [RATIO_W-1:0] launch_ratio;
        logic [RATIO_W-1:0] main_ratio;
        logic [COUNT_W-1:0] confirm;
        logic [TIME_W-1:0]  ascent_to;
        logic [TIME_W-1:0]  drogue_to;
    } t_cfg;

    typedef enum logic [3:0] {
        PH_PREFLIGHT = 4'b0001,
        PH_ASCENT    = 4'b0010,
        PH_DROGUE    = 4'b0100,
        PH_MAIN      = 4'b1000
    } t_phase;

    localparam logic [PHASE_W-1:0] PHASE_CODE_PREFLIGHT = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_ASCENT    = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_DROGUE    = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_CODE_MAIN      = 2'd3;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               fire_drogue;
        logic               fire_main;
        logic               accel_neg;
    } t_flags;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_PREFLIGHT: code = PHASE_CODE_PREFLIGHT;
            PH_ASCENT:    code = PHASE_CODE_ASCENT;
            PH_DROGUE:    code = PHASE_CODE_DROGUE;
            PH_MAIN:      code = PHASE_CODE_MAIN;
            default:      code = PHASE_CODE_PREFLIGHT;
        endcase
        return code;
    endfunction

endpackage

### sv/fps_cfg.sv
// ----------------------------------------------------------------------------
// fps_cfg
// Configuration register file: write-only, one register per index.
// ----------------------------------------------------------------------------
module fps_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [fps_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fps_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output fps_pkg::t_cfg                      o_cfg,
    output fps_pkg::t_cfg                      o_cfg_nxt,
    output logic                               o_confirm_wr
);

    fps_pkg::t_cfg r_cfg;
    fps_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg        = r_cfg;
        o_confirm_wr = 1'b0;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                fps_pkg::CFG_LAUNCH_ACCEL: begin
                    n_cfg.accel_thr = i_cfg_wdata[fps_pkg::ACCEL_W-1:0];
                end
                fps_pkg::CFG_LAUNCH_RATIO: begin
                    n_cfg.launch_ratio = i_cfg_wdata[fps_pkg::RATIO_W-1:0];
                end
                fps_pkg::CFG_MAIN_RATIO: begin
                    n_cfg.main_ratio = i_cfg_wdata[fps_pkg::RATIO_W-1:0];
                end
                fps_pkg::CFG_CONFIRM: begin
                    n_cfg.confirm = i_cfg_wdata[fps_pkg::COUNT_W-1:0];
                    o_confirm_wr  = 1'b1;
                end
                fps_pkg::CFG_ASCENT_TO: begin
                    n_cfg.ascent_to = i_cfg_wdata[fps_pkg::TIME_W-1:0];
                end
                fps_pkg::CFG_DROGUE_TO: begin
                    n_cfg.drogue_to = i_cfg_wdata[fps_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_thr    <= fps_pkg::RST_ACCEL_THR;
            r_cfg.launch_ratio <= fps_pkg::RST_LAUNCH_RATIO;
            r_cfg.main_ratio   <= fps_pkg::RST_MAIN_RATIO;
            r_cfg.confirm      <= fps_pkg::RST_CONFIRM;
            r_cfg.ascent_to    <= fps_pkg::RST_ASCENT_TO;
            r_cfg.drogue_to    <= fps_pkg::RST_DROGUE_TO;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg     = r_cfg;
    assign o_cfg_nxt = n_cfg;

endmodule

### sv/fps_core.sv
// ----------------------------------------------------------------------------
// fps_core
// Sample histories, running sums, minimum pressure and the phase sequencer.
// State advances on each accepted transaction; results leave combinationally.
// ----------------------------------------------------------------------------
module fps_core #(
    parameter int HISTORY_DEPTH = fps_pkg::HISTORY_DEPTH_DEF,
    parameter int PSUM_W        = fps_pkg::PRESSURE_W + $clog2(HISTORY_DEPTH),
    parameter int ASUM_W        = fps_pkg::ACCEL_W + $clog2(HISTORY_DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_baro_valid,
    input  logic                              i_imu_valid,
    input  logic [fps_pkg::PRESSURE_W-1:0]    i_pressure_pa,
    input  logic [fps_pkg::ACCEL_W-1:0]       i_vert_accel,
    input  logic [fps_pkg::TIME_W-1:0]        i_time_ms,
    input  logic                              i_drogue_fire_ok,
    input  fps_pkg::t_cfg                     i_cfg,
    input  fps_pkg::t_cfg                     i_cfg_nxt,
    input  logic                              i_confirm_wr,
    output fps_pkg::t_flags                   o_flags,
    output logic [PSUM_W-1:0]                 o_psum,
    output logic [ASUM_W-1:0]                 o_asum
);

    localparam int PW   = fps_pkg::PRESSURE_W;
    localparam int AW   = fps_pkg::ACCEL_W;
    localparam int LIMW = fps_pkg::PRESSURE_W + fps_pkg::RATIO_W;
    localparam int SCLW = PSUM_W + fps_pkg::RATIO_W;

    localparam logic        [PSUM_W-1:0] D_PS  = PSUM_W'(HISTORY_DEPTH);
    localparam logic        [SCLW-1:0]   D_SCL = SCLW'(HISTORY_DEPTH);
    localparam logic signed [ASUM_W:0]   D_AS  = (ASUM_W+1)'(HISTORY_DEPTH);

    fps_pkg::t_phase r_phase, n_phase;
    logic                          r_ground_ok;
    logic [PW-1:0]                 r_ground, n_ground;
    logic [PW-1:0]                 r_min, n_min;
    logic [PW-1:0]                 r_phist [HISTORY_DEPTH];
    logic [AW-1:0]                 r_ahist [HISTORY_DEPTH];
    logic [PSUM_W-1:0]             r_psum, n_psum;
    logic signed [ASUM_W-1:0]      r_asum, n_asum;
    logic [fps_pkg::COUNT_W-1:0]   r_cd, n_cd;
    logic [fps_pkg::TIME_W-1:0]    r_entry, n_entry;
    logic [LIMW-1:0]               r_llim, r_mlim;

    logic                          latch;
    logic [SCLW-1:0]               scaled, llim_scl, mlim_scl;
    logic signed [ASUM_W:0]        thr_scl;
    logic [fps_pkg::TIME_W-1:0]    elapsed;
    logic                          launch, past_min, low, go;
    logic                          fire_d, fire_m;

    always_comb begin
        latch    = i_baro_valid && !r_ground_ok;
        n_ground = latch ? i_pressure_pa : r_ground;

        n_psum = r_psum;
        n_min  = r_min;
        if (i_baro_valid) begin
            if (latch) begin
                n_psum = PSUM_W'(i_pressure_pa) * D_PS;
            end else begin
                n_psum = r_psum + PSUM_W'(i_pressure_pa) - PSUM_W'(r_phist[HISTORY_DEPTH-1]);
            end
            if (i_pressure_pa < r_min) begin
                n_min = i_pressure_pa;
            end
        end

        n_asum = r_asum;
        if (i_imu_valid) begin
            n_asum = r_asum + $signed(i_vert_accel) - $signed(r_ahist[HISTORY_DEPTH-1]);
        end

        scaled   = {n_psum, {fps_pkg::RATIO_W{1'b0}}};
        llim_scl = SCLW'(r_llim) * D_SCL;
        mlim_scl = SCLW'(r_mlim) * D_SCL;
        thr_scl  = $signed(i_cfg.accel_thr) * D_AS;
        elapsed  = i_time_ms - r_entry;

        // on the latching sample the average equals the ground pressure
        launch   = (i_imu_valid && (n_asum > thr_scl))
                || (i_baro_valid && !latch && (scaled < llim_scl));
        past_min = i_baro_valid && (n_psum > (PSUM_W'(n_min) * D_PS));
        low      = i_baro_valid && (latch ? (i_pressure_pa != '0) : (scaled > mlim_scl));

        n_phase = r_phase;
        n_entry = r_entry;
        n_cd    = r_cd;
        go      = 1'b0;
        fire_d  = 1'b0;
        fire_m  = 1'b0;
        unique case (r_phase)
            fps_pkg::PH_PREFLIGHT: begin
                if (launch) begin
                    n_phase = fps_pkg::PH_ASCENT;
                    n_entry = i_time_ms;
                end
            end
            fps_pkg::PH_ASCENT: begin
                if (past_min) begin
                    n_cd = (r_cd != '0) ? r_cd - 1'b1 : r_cd;
                end else begin
                    n_cd = i_cfg.confirm;
                end
                go = (n_cd == '0) || (elapsed > i_cfg.ascent_to);
                if (go) begin
                    fire_d = 1'b1;
                    if (i_drogue_fire_ok) begin
                        n_phase = fps_pkg::PH_DROGUE;
                        n_entry = i_time_ms;
                    end
                end
            end
            fps_pkg::PH_DROGUE: begin
                if (low || (elapsed > i_cfg.drogue_to)) begin
                    fire_m  = 1'b1;
                    n_phase = fps_pkg::PH_MAIN;
                    n_entry = i_time_ms;
                end
            end
            fps_pkg::PH_MAIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= fps_pkg::PH_PREFLIGHT;
            r_ground_ok <= 1'b0;
            r_ground    <= '0;
            r_min       <= '1;
            r_psum      <= '0;
            r_asum      <= '0;
            r_cd        <= fps_pkg::RST_CONFIRM;
            r_entry     <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_ahist[i] <= '0;
            end
        end else begin
            if (i_confirm_wr) begin
                r_cd <= i_cfg_nxt.confirm;
            end
            if (i_accept) begin
                r_phase     <= n_phase;
                r_ground_ok <= r_ground_ok || i_baro_valid;
                r_ground    <= n_ground;
                r_min       <= n_min;
                r_psum      <= n_psum;
                r_asum      <= n_asum;
                r_cd        <= n_cd;
                r_entry     <= n_entry;
                if (i_imu_valid) begin
                    r_ahist[0] <= i_vert_accel;
                    for (int i = 1; i < HISTORY_DEPTH; i++) begin
                        r_ahist[i] <= r_ahist[i-1];
                    end
                end
            end
        end
    end

    // pressure line: oldest sample at the tail, all taps loaded on the first valid sample
    always_ff @(posedge i_clk) begin
        if (i_accept && i_baro_valid) begin
            r_phist[0] <= i_pressure_pa;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
                r_phist[i] <= latch ? i_pressure_pa : r_phist[i-1];
            end
        end
    end

    // altitude limits track the next ground pressure and ratios
    always_ff @(posedge i_clk) begin
        r_llim <= LIMW'(n_ground) * LIMW'(i_cfg_nxt.launch_ratio);
        r_mlim <= LIMW'(n_ground) * LIMW'(i_cfg_nxt.main_ratio);
    end

    assign o_flags.phase       = fps_pkg::phase_code(n_phase);
    assign o_flags.fire_drogue = fire_d;
    assign o_flags.fire_main   = fire_m;
    assign o_flags.accel_neg   = n_asum[ASUM_W-1];
    assign o_psum              = n_psum;
    assign o_asum              = n_asum;

endmodule

### sv/fps_cdiv.sv
// ----------------------------------------------------------------------------
// fps_cdiv
// Unsigned divide by a constant: reciprocal multiply, then one correction.
// Two register stages, each with its own load enable.
// ----------------------------------------------------------------------------
module fps_cdiv #(
    parameter int WIDTH   = fps_pkg::PRESSURE_W + $clog2(fps_pkg::HISTORY_DEPTH_DEF),
    parameter int DIVISOR = fps_pkg::HISTORY_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_en_mul,
    input  logic [WIDTH-1:0] i_num,
    input  logic             i_en_fix,
    output logic [WIDTH-1:0] o_quot
);

    localparam longint unsigned MULT_L = (64'd1 << WIDTH) / DIVISOR;
    localparam logic [WIDTH-1:0] MULT  = WIDTH'(MULT_L);
    localparam logic [WIDTH-1:0] DIV_W = WIDTH'(DIVISOR);

    logic [2*WIDTH-1:0] prod;
    logic [WIDTH-1:0]   r_num;
    logic [WIDTH-1:0]   r_qest;
    logic [WIDTH-1:0]   rem;
    logic [WIDTH-1:0]   n_quot;
    logic [WIDTH-1:0]   r_quot;

    // estimate is the true quotient or one below it
    assign prod   = i_num * MULT;
    assign rem    = r_num - r_qest * DIV_W;
    assign n_quot = (rem >= DIV_W) ? r_qest + 1'b1 : r_qest;

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_num  <= i_num;
            r_qest <= prod[2*WIDTH-1:WIDTH];
        end
        if (i_en_fix) begin
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

### sv/flight_phase_sequencer.sv
// Each accepted result is registered after the core, the multiply and the correction.
// Throughput: one transaction per cycle while the output is not stalled; three
// results can be held against a stalled output before the input stalls.
// Depth set by the history averages: reciprocal multiply then correction stage.
// Reset (synchronous, active low): preflight, no ground pressure, zero
// acceleration history, configuration back to defaults, pipeline emptied.
// ----------------------------------------------------------------------------
// flight_phase_sequencer
// Apogee detection and parachute deployment controller for one sensor stream.
// ----------------------------------------------------------------------------
module flight_phase_sequencer #(
    parameter int HISTORY_DEPTH = fps_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [fps_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [fps_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // pressure_pa[16:0], vert_accel[35:17], time_ms[67:36], drogue_fire_ok[68], zero pad
    input  logic [fps_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    // baro_valid[0], imu_valid[1]
    input  logic [fps_pkg::IN_TUSER_W-1:0]       i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // flight_phase[1:0], fire_drogue[2], fire_main[3], avg_pressure[20:4],
    // avg_accel[39:21]
    output logic [fps_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int PSUM_W = fps_pkg::PRESSURE_W + $clog2(HISTORY_DEPTH);
    localparam int ASUM_W = fps_pkg::ACCEL_W + $clog2(HISTORY_DEPTH);
    localparam int PW     = fps_pkg::PRESSURE_W;
    localparam int AW     = fps_pkg::ACCEL_W;

    fps_pkg::t_cfg   cfg, cfg_nxt;
    logic            confirm_wr;
    fps_pkg::t_flags core_flags;
    logic [PSUM_W-1:0] core_psum;
    logic [ASUM_W-1:0] core_asum;

    logic rdy1, rdy2, rdy3, accept;
    logic r_v1, r_v2, r_v3;
    fps_pkg::t_flags r_flags1, r_flags2, r_flags3;
    logic [PSUM_W-1:0] r_psum1;
    logic [ASUM_W-1:0] r_asum1;
    logic [ASUM_W-2:0] amag;
    logic [PSUM_W-1:0] pquot;
    logic [ASUM_W-2:0] aquot;
    logic [AW-1:0]     avg_accel;

    assign rdy3   = !r_v3 || i_m_axis_tready;
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign accept = i_s_axis_tvalid && rdy1;

    fps_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_cfg        (cfg),
        .o_cfg_nxt    (cfg_nxt),
        .o_confirm_wr (confirm_wr)
    );

    fps_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PSUM_W        (PSUM_W),
        .ASUM_W        (ASUM_W)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_baro_valid     (i_s_axis_tuser[fps_pkg::IN_BARO_VALID]),
        .i_imu_valid      (i_s_axis_tuser[fps_pkg::IN_IMU_VALID]),
        .i_pressure_pa    (i_s_axis_tdata[fps_pkg::IN_PRESSURE_LSB +: PW]),
        .i_vert_accel     (i_s_axis_tdata[fps_pkg::IN_ACCEL_LSB +: AW]),
        .i_time_ms        (i_s_axis_tdata[fps_pkg::IN_TIME_LSB +: fps_pkg::TIME_W]),
        .i_drogue_fire_ok (i_s_axis_tdata[fps_pkg::IN_DROGUE_OK]),
        .i_cfg            (cfg),
        .i_cfg_nxt        (cfg_nxt),
        .i_confirm_wr     (confirm_wr),
        .o_flags          (core_flags),
        .o_psum           (core_psum),
        .o_asum           (core_asum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= accept;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_flags1 <= core_flags;
            r_psum1  <= core_psum;
            r_asum1  <= core_asum;
        end
        if (rdy2) begin
            r_flags2 <= r_flags1;
        end
        if (rdy3) begin
            r_flags3 <= r_flags2;
        end
    end

    // floor of a negative mean: divide -sum-1, then invert
    assign amag = r_flags1.accel_neg ? ~r_asum1[ASUM_W-2:0] : r_asum1[ASUM_W-2:0];

    fps_cdiv #(
        .WIDTH   (PSUM_W),
        .DIVISOR (HISTORY_DEPTH)
    ) u_pdiv (
        .i_clk    (i_clk),
        .i_en_mul (rdy2),
        .i_num    (r_psum1),
        .i_en_fix (rdy3),
        .o_quot   (pquot)
    );

    fps_cdiv #(
        .WIDTH   (ASUM_W-1),
        .DIVISOR (HISTORY_DEPTH)
    ) u_adiv (
        .i_clk    (i_clk),
        .i_en_mul (rdy2),
        .i_num    (amag),
        .i_en_fix (rdy3),
        .o_quot   (aquot)
    );

    assign avg_accel = r_flags3.accel_neg ? ~aquot[AW-1:0] : aquot[AW-1:0];

    assign o_s_axis_tready = rdy1;
    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = {avg_accel, pquot[PW-1:0], r_flags3.fire_main,
                              r_flags3.fire_drogue, r_flags3.phase};

endmodule

### sv/fps_checker.sv
// ----------------------------------------------------------------------------
// fps_checker
// Port-level checks on the result stream of the flight phase sequencer.
// ----------------------------------------------------------------------------
`include "flight_phase_sequencer_defines.svh"

module fps_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [fps_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    logic [fps_pkg::PHASE_W-1:0] phase;
    logic                        fire_d;
    logic                        fire_m;

    assign phase  = o_m_axis_tdata[fps_pkg::OUT_PHASE_LSB +: fps_pkg::PHASE_W];
    assign fire_d = o_m_axis_tdata[fps_pkg::OUT_FIRE_DROGUE];
    assign fire_m = o_m_axis_tdata[fps_pkg::OUT_FIRE_MAIN];

    `FPS_ASSERT_SAME(a_one_firing, i_clk, i_rst_n, o_m_axis_tvalid, !(fire_d && fire_m), "drogue and main fired on one transaction")
    `FPS_ASSERT_SAME(a_main_phase, i_clk, i_rst_n, o_m_axis_tvalid && fire_m, phase == fps_pkg::PHASE_CODE_MAIN, "main fired outside main descent")
    `FPS_ASSERT_SAME(a_drogue_phase, i_clk, i_rst_n, o_m_axis_tvalid && fire_d, (phase == fps_pkg::PHASE_CODE_ASCENT) || (phase == fps_pkg::PHASE_CODE_DROGUE), "drogue fired outside ascent or drogue descent")
    `FPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

endmodule

bind flight_phase_sequencer fps_checker u_fps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
